// ----- hw/rtl/ptq_pkg.sv -----
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types, request and status codes, and sizes of the priority task queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 5;
  localparam int ID_W        = 16;
  localparam int PRIO_W      = 8;
  localparam int WAIT_W      = 16;
  localparam int REQ_W       = 2;
  localparam int STAT_W      = 2;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 48;

  typedef enum logic [REQ_W-1:0] {
    REQ_PRIO_INS = 2'd0,
    REQ_TAIL_APP = 2'd1,
    REQ_DEQ_HEAD = 2'd2,
    REQ_REM_MAXW = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [WAIT_W-1:0] wait_time;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_PLACE,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic shift_up;
    logic shift_dn;
    logic init_up;
    logic init_dn;
    logic place;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic is_ins;
    logic walk_done;
    logic need_shift;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hw/rtl/ptq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptq_ctrl
// Sequencer: scan for the position, shift entries, place an inserted task, then post result;
// a step that a request does not need is skipped.
module ptq_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  ptq_pkg::req_t             in_req,
  output logic                      in_tready,
  input  ptq_pkg::dp_sts_t          sts,
  output ptq_pkg::dp_cmd_t          cmd
);

  ptq_pkg::state_t state_r;
  ptq_pkg::state_t state_nxt;
  logic            req_ins;

  assign req_ins = (in_req == ptq_pkg::REQ_PRIO_INS) || (in_req == ptq_pkg::REQ_TAIL_APP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ptq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          priority if ((req_ins && sts.full) || (!req_ins && sts.empty)) begin
            state_nxt = ptq_pkg::S_DONE;
          end else if (in_req == ptq_pkg::REQ_TAIL_APP) begin
            state_nxt = ptq_pkg::S_PLACE;
          end else begin
            state_nxt = ptq_pkg::S_SCAN;
          end
        end
      end
      ptq_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.walk_done) begin
          priority if (sts.need_shift && sts.is_ins) begin
            cmd.init_up = 1'b1;
            state_nxt   = ptq_pkg::S_SHUP;
          end else if (sts.need_shift) begin
            cmd.init_dn = 1'b1;
            state_nxt   = ptq_pkg::S_SHDN;
          end else if (sts.is_ins) begin
            state_nxt = ptq_pkg::S_PLACE;
          end else begin
            state_nxt = ptq_pkg::S_DONE;
          end
        end
      end
      ptq_pkg::S_SHUP: begin
        cmd.shift_up = 1'b1;
        if (sts.walk_done) begin
          state_nxt = ptq_pkg::S_PLACE;
        end
      end
      ptq_pkg::S_SHDN: begin
        cmd.shift_dn = 1'b1;
        if (sts.walk_done) begin
          state_nxt = ptq_pkg::S_DONE;
        end
      end
      ptq_pkg::S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = ptq_pkg::S_DONE;
      end
      ptq_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ptq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ptq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/ptq_datapath.sv -----
// ----------------------------------------------------------------------------
// ptq_datapath
// Entry store, walk pointer with a registered read, search registers,
// entry count and the result register.
// ----------------------------------------------------------------------------
module ptq_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ptq_pkg::dp_cmd_t            cmd,
  output ptq_pkg::dp_sts_t            sts,
  input  ptq_pkg::req_t               in_req,
  input  ptq_pkg::entry_t             in_entry,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output ptq_pkg::status_t            res_status,
  output logic                        res_valid,
  output ptq_pkg::entry_t             res_entry,
  output logic [ptq_pkg::OCC_W-1:0]   res_occ
);

  localparam int IDX_W = ptq_pkg::IDX_W;
  localparam int CNT_W = ptq_pkg::CNT_W;

  ptq_pkg::entry_t mem [ptq_pkg::QUEUE_DEPTH];

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] scan_end_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] paddr_r;
  logic             walk_act_r;
  logic             pv_r;
  logic             found_r;
  logic             fail_r;
  logic             out_tvalid_r;
  ptq_pkg::req_t    req_r;
  ptq_pkg::entry_t  ent_r;
  ptq_pkg::entry_t  best_r;
  ptq_pkg::entry_t  rd_q_r;

  logic             is_ins_in;
  logic             is_ins;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] scan_end_in;
  logic             walking;
  logic             last_issue;
  logic             we;
  logic [IDX_W-1:0] waddr;
  ptq_pkg::entry_t  wdata;

  assign is_ins_in = (in_req == ptq_pkg::REQ_PRIO_INS) || (in_req == ptq_pkg::REQ_TAIL_APP);
  assign is_ins    = (req_r == ptq_pkg::REQ_PRIO_INS) || (req_r == ptq_pkg::REQ_TAIL_APP);
  assign full      = (count_r == CNT_W'(ptq_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign scan_end_in = (in_req == ptq_pkg::REQ_DEQ_HEAD) ? CNT_W'(1) : count_r;

  assign walking = walk_act_r && (cmd.scan || cmd.shift_up || cmd.shift_dn);

  always_comb begin
    last_issue = 1'b0;
    priority if (cmd.shift_up) begin
      last_issue = (idx_r == pos_r);
    end else if (cmd.shift_dn) begin
      last_issue = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
    end else begin
      last_issue = ((CNT_W'(idx_r) + CNT_W'(1)) == scan_end_r);
    end
  end

  // shift writes trail the registered read, the final place writes the new task
  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = ent_r;
    priority if (pv_r && cmd.shift_up) begin
      we    = 1'b1;
      waddr = paddr_r + IDX_W'(1);
      wdata = rd_q_r;
    end else if (pv_r && cmd.shift_dn) begin
      we    = 1'b1;
      waddr = paddr_r - IDX_W'(1);
      wdata = rd_q_r;
    end else if (cmd.place) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (walking) begin
      rd_q_r <= mem[idx_r];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (!fail_r) begin
      count_nxt = is_ins ? (count_r + CNT_W'(1)) : (count_r - CNT_W'(1));
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      walk_act_r   <= 1'b0;
      pv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      pv_r <= walking;
      if (cmd.load) begin
        walk_act_r <= !(is_ins_in ? full : empty) && (in_req != ptq_pkg::REQ_TAIL_APP)
                      && (scan_end_in != '0);
      end else if (cmd.init_up || cmd.init_dn) begin
        walk_act_r <= 1'b1;
      end else if (walking && last_issue) begin
        walk_act_r <= 1'b0;
      end
      if (cmd.finish) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // request, walk and search payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= in_req;
      ent_r      <= in_entry;
      fail_r     <= is_ins_in ? full : empty;
      scan_end_r <= scan_end_in;
      idx_r      <= '0;
      found_r    <= 1'b0;
      pos_r      <= is_ins_in ? IDX_W'(count_r) : '0;
    end else if (cmd.init_up) begin
      idx_r <= IDX_W'(count_r - CNT_W'(1));
    end else if (cmd.init_dn) begin
      idx_r <= pos_r + IDX_W'(1);
    end else if (walking && !last_issue) begin
      idx_r <= cmd.shift_up ? (idx_r - IDX_W'(1)) : (idx_r + IDX_W'(1));
    end
    if (walking) begin
      paddr_r <= idx_r;
    end
    if (pv_r && cmd.scan) begin
      if (req_r == ptq_pkg::REQ_PRIO_INS) begin
        if (!found_r && (rd_q_r.prio <= ent_r.prio)) begin
          found_r <= 1'b1;
          pos_r   <= paddr_r;
        end
      end else if ((paddr_r == '0) ||
                   ((req_r == ptq_pkg::REQ_REM_MAXW) && (rd_q_r.wait_time > best_r.wait_time))) begin
        best_r <= rd_q_r;
        pos_r  <= paddr_r;
      end
    end
    if (cmd.finish) begin
      res_valid <= !fail_r && !is_ins;
      res_entry <= (!fail_r && !is_ins) ? best_r : '0;
      res_occ   <= ptq_pkg::OCC_W'(count_nxt);
      priority if (fail_r && is_ins) begin
        res_status <= ptq_pkg::ST_FULL;
      end else if (fail_r) begin
        res_status <= ptq_pkg::ST_EMPTY;
      end else begin
        res_status <= ptq_pkg::ST_OK;
      end
    end
  end

  assign out_tvalid     = out_tvalid_r;
  assign sts.full       = full;
  assign sts.empty      = empty;
  assign sts.is_ins     = is_ins;
  assign sts.walk_done  = !walk_act_r && !pv_r;
  assign sts.need_shift = is_ins ? (CNT_W'(pos_r) < count_r)
                                 : ((CNT_W'(pos_r) + CNT_W'(1)) < count_r);
  assign sts.out_free   = !out_tvalid_r || out_tready;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ptq_pkg::QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_tvalid_r || out_tready))
    else $error("result posted over an unsent result");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    walking |-> (CNT_W'(idx_r) < count_r))
    else $error("walk reads beyond the held entries");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> ((count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1)) ||
                    (count_r == $past(count_r) - CNT_W'(1))))
    else $error("entry count moved by more than one");

endmodule

// ----- hw/rtl/priority_task_queue.sv -----
// ----------------------------------------------------------------------------
// priority_task_queue
// Bounded task queue with priority insert, tail append, head dequeue and
// remove-largest-wait, built as a sequencer over an entry store with one read and one write port.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in_      slave      in_tvalid/in_tready    req_type, task_id, task_priority, task_wait
//  out_     master     out_tvalid/out_tready  status, out_valid, out_id, out_priority,
//                                             out_wait, occupancy
//
//  path to result: a refused request goes straight to the result, a tail append places
//  the task at once; an insert scans, shifts entries up and places, a removal scans and
//  shifts entries down; the scan covers the held entries (one for a head dequeue) and
//  the shift is skipped with none to move; the store is walked one entry per cycle
//  one request in flight; a new request is taken once its predecessor's result is
//  in the output register, which holds it until out_tready
//  synchronous active-low reset empties the queue; the store itself is not cleared
// ----------------------------------------------------------------------------
module priority_task_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // req_type[1:0], task_id[17:2], task_priority[25:18], task_wait[41:26], zero pad
  input  logic [ptq_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[1:0], out_valid[2], out_id[18:3], out_priority[26:19], out_wait[42:27],
  // occupancy[47:43]
  output logic [ptq_pkg::OUT_DATA_W-1:0]    out_tdata
);

  ptq_pkg::dp_cmd_t               cmd;
  ptq_pkg::dp_sts_t               sts;
  ptq_pkg::req_t                  in_req;
  ptq_pkg::entry_t                in_entry;
  ptq_pkg::status_t               res_status;
  logic                           res_valid;
  ptq_pkg::entry_t                res_entry;
  logic [ptq_pkg::OCC_W-1:0]      res_occ;

  assign in_req             = ptq_pkg::req_t'(in_tdata[1:0]);
  assign in_entry.id        = in_tdata[17:2];
  assign in_entry.prio      = in_tdata[25:18];
  assign in_entry.wait_time = in_tdata[41:26];

  assign out_tdata = {res_occ, res_entry.wait_time, res_entry.prio, res_entry.id,
                      res_valid, res_status};

  ptq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_req    (in_req),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_req     (in_req),
    .in_entry   (in_entry),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .res_status (res_status),
    .res_valid  (res_valid),
    .res_entry  (res_entry),
    .res_occ    (res_occ)
  );

endmodule
